// ===== hw/rtl/fmcd_pkg.sv =====
// Shared types, constants and helper functions of the framed motor command decoder.
package fmcd_pkg;

  localparam int FRAME_BYTES_DEFAULT = 16;
  // Bytes of a frame that decoding looks at (positions 0 through 14).
  localparam int DECODE_BYTES = 15;
  // Bytes covered by the set-target checksum.
  localparam int CRC_BYTES = 7;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [7:0] byte_t;
  typedef logic [DECODE_BYTES-1:0][7:0] frame_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEAD = 2'd0;
  localparam logic [1:0] REG_TAIL = 2'd1;
  localparam logic [1:0] REG_ADDR = 2'd2;

  // Frame byte values.
  localparam byte_t FN_WRITE     = 8'h01;
  localparam byte_t OP_START     = 8'h01;
  localparam byte_t OP_RESET     = 8'h02;
  localparam byte_t OP_TARGET    = 8'h03;
  localparam byte_t OP_POS_PID   = 8'h04;
  localparam byte_t OP_VEL_PID   = 8'h05;
  localparam byte_t OP_MODE      = 8'h06;
  localparam byte_t OP_DIR       = 8'h07;
  localparam byte_t OP_POLES     = 8'h08;

  // Result command codes.
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_RESET   = 3'd1;
  localparam logic [2:0] CMD_TARGET  = 3'd2;
  localparam logic [2:0] CMD_POS_PID = 3'd3;
  localparam logic [2:0] CMD_VEL_PID = 3'd4;
  localparam logic [2:0] CMD_MODE    = 3'd5;
  localparam logic [2:0] CMD_DIR     = 3'd6;
  localparam logic [2:0] CMD_POLES   = 3'd7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    byte_t head_byte;
    byte_t tail_byte;
    byte_t device_address;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  command;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
  } result_t;

  // One byte of CRC-16/Modbus, reflected.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input byte_t d);
    logic [15:0] c;
    c = crc_in ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] word_at(input frame_t f, input int pos);
    return {f[pos], f[pos+1], f[pos+2], f[pos+3]};
  endfunction

  // Classify a closed frame; crc is the checksum of bytes 0..6 when byte 2 selects set target.
  function automatic result_t decode_frame(input frame_t f, input byte_t addr,
                                           input logic [15:0] crc);
    result_t r;
    r = '0;
    if (f[0] == addr && f[1] == FN_WRITE) begin
      case (f[2])
        OP_START: begin
          r.ok = (f[3] == 8'h00);
          r.command = CMD_START;
        end
        OP_RESET: begin
          r.ok = (f[3] == 8'h00);
          r.command = CMD_RESET;
        end
        OP_TARGET: begin
          r.ok = (crc == {f[8], f[7]});
          r.command = CMD_TARGET;
          r.value_a = word_at(f, 3);
        end
        OP_POS_PID, OP_VEL_PID: begin
          r.ok = 1'b1;
          r.command = (f[2] == OP_POS_PID) ? CMD_POS_PID : CMD_VEL_PID;
          r.value_a = word_at(f, 3);
          r.value_b = word_at(f, 7);
          r.value_c = word_at(f, 11);
        end
        OP_MODE: begin
          r.ok = 1'b1;
          r.command = CMD_MODE;
          r.value_a = {24'h000000, f[3]};
        end
        OP_DIR: begin
          r.ok = 1'b1;
          r.command = CMD_DIR;
          r.value_a = {24'h000000, f[3]};
        end
        OP_POLES: begin
          r.ok = 1'b1;
          r.command = CMD_POLES;
          r.value_a = {24'h000000, f[3]};
        end
        default: begin
          r.ok = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fmcd_front.sv =====
// Byte classifier and frame assembler: keeps the frame store and pushes closed frames.
module fmcd_front #(
  parameter int FRAME_BYTES = fmcd_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  fmcd_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  fmcd_pkg::byte_t   rx_byte,
  input  fmcd_pkg::q_status_t q_status,
  output logic              push,
  output fmcd_pkg::frame_t  push_frame
);
  import fmcd_pkg::*;

  localparam int LEN_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FRAME_BYTES);

  logic [FRAME_BYTES-1:0][7:0] frame_store;
  logic                        in_frame;
  logic [LEN_W-1:0]            frame_length;
  logic                        accept;
  logic                        is_head;
  logic                        is_tail;

  // Hold the byte stream while the queue has no room for a closed frame.
  assign in_stall   = q_status.full;
  assign accept     = in_valid && !in_stall;
  assign is_head    = (rx_byte == cfg.head_byte);
  assign is_tail    = (rx_byte == cfg.tail_byte);
  assign push       = accept && !is_head && in_frame && is_tail;
  assign push_frame = frame_store[DECODE_BYTES-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      frame_length <= '0;
      frame_store  <= '0;
    end else if (accept) begin
      if (is_head) begin
        in_frame       <= 1'b1;
        frame_store[0] <= rx_byte;
        frame_length   <= LEN_W'(1);
      end else if (in_frame) begin
        if (is_tail) begin
          in_frame     <= 1'b0;
          frame_length <= '0;
        end else if (frame_length < LEN_MAX) begin
          frame_store[frame_length[IDX_W-1:0]] <= rx_byte;
          frame_length <= frame_length + LEN_W'(1);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/fmcd_queue.sv =====
// Short register queue of closed frames between front and back.
module fmcd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fmcd_pkg::frame_t    push_frame,
  input  logic                pop,
  output fmcd_pkg::frame_t    pop_frame,
  output fmcd_pkg::q_status_t status
);
  import fmcd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_t           entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_frame    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/fmcd_back.sv =====
// Frame decoder: checksum sequencer, command classification and result register.
module fmcd_back (
  input  logic                clk,
  input  logic                rst,
  input  fmcd_pkg::byte_t     device_address,
  input  fmcd_pkg::q_status_t q_status,
  input  fmcd_pkg::frame_t    pop_frame,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          command,
  output logic [31:0]         value_a,
  output logic [31:0]         value_b,
  output logic [31:0]         value_c
);
  import fmcd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRC  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int CNT_W = $clog2(CRC_BYTES);
  localparam int IDX_W = $clog2(DECODE_BYTES);

  logic [1:0]       state;
  frame_t           work;
  logic [15:0]      crc;
  logic [CNT_W-1:0] cnt;
  result_t          res;
  logic             slot_free;

  assign pop       = (state == S_IDLE) && !q_status.empty;
  assign slot_free = !out_valid || !out_stall;
  assign res       = decode_frame(work, device_address, crc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // Load a new result, or drop the current one once it is taken.
      if (state == S_DONE && slot_free && res.ok) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            cnt   <= '0;
            state <= (pop_frame[2] == OP_TARGET) ? S_CRC : S_DONE;
          end
        end
        S_CRC: begin
          // Advance one frame byte per cycle through the checksum.
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(CRC_BYTES - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= pop_frame;
      crc  <= CRC_INIT;
    end else if (state == S_CRC) begin
      crc <= crc_byte(crc, work[IDX_W'(cnt)]);
    end
    if (state == S_DONE && slot_free && res.ok) begin
      command <= res.command;
      value_a <= res.value_a;
      value_b <= res.value_b;
      value_c <= res.value_c;
    end
  end

endmodule

// ===== hw/rtl/framed_motor_command_decoder.sv =====
// Top level of the framed motor command decoder: config registers, front, queue and back.
//
// Takes received bytes, one per transaction on the input channel, and turns framed
// commands into at most one result transaction per frame. A head byte always restarts
// a frame and is kept as byte 0; a tail byte closes it. The front accepts one byte per
// cycle and only stalls the input when the two-entry frame queue is full. The back
// decodes one queued frame at a time; for set target a checksum state comes before decoding,
// where the CRC-16/Modbus over bytes 0..6 runs one byte per cycle. Results wait in an
// output register, so the back keeps decoding while the front keeps collecting bytes.
// Frames that fail the address, write-function, opcode, zero-argument or checksum tests
// give no result. The frame store is cleared in the reset cycle itself; no sweep is
// needed. Write configuration registers (head, tail, device address) only while idle.
module framed_motor_command_decoder #(
  parameter int FRAME_BYTES = fmcd_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // command result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  command,
  output logic [31:0] value_a,
  output logic [31:0] value_b,
  output logic [31:0] value_c
);
  import fmcd_pkg::*;

  cfg_t      cfg;
  q_status_t q_status;
  logic      push;
  frame_t    push_frame;
  logic      pop;
  frame_t    pop_frame;

  // Configuration writes always complete; drop writes to indexes past the list.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_byte      <= 8'hAA;
      cfg.tail_byte      <= 8'h55;
      cfg.device_address <= 8'hAA;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEAD: cfg.head_byte      <= cfg_data;
        REG_TAIL: cfg.tail_byte      <= cfg_data;
        REG_ADDR: cfg.device_address <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: classify bytes and assemble frames.
  fmcd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .q_status  (q_status),
    .push      (push),
    .push_frame(push_frame)
  );

  // Queue: decouple frame collection from decoding.
  fmcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_frame(push_frame),
    .pop       (pop),
    .pop_frame (pop_frame),
    .status    (q_status)
  );

  // Back: checksum, classify and hold the result until taken.
  fmcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .device_address(cfg.device_address),
    .q_status      (q_status),
    .pop_frame     (pop_frame),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command       (command),
    .value_a       (value_a),
    .value_b       (value_b),
    .value_c       (value_c)
  );

endmodule
